/* src/iws_pkg.sv */
// Shared types, codes and constants of the interval workout sequencer.
package iws_pkg;

    localparam int TIMER_WIDTH     = 40;
    localparam int OUT_TIME_WIDTH  = 40;
    localparam int CFG_WIDTH       = 26;
    localparam int SECS_WIDTH      = 16;
    localparam int SPEED_WIDTH     = 10;
    localparam int COUNT_WIDTH     = 8;
    localparam int ELAPSED_WIDTH   = 16;
    localparam int OPCODE_WIDTH    = 2;
    localparam int STATUS_WIDTH    = 2;
    localparam int PHASE_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_PHASES      = 4;
    localparam int PHASE_IDX_WIDTH = $clog2(NUM_PHASES);
    localparam int DUR_WIDTH       = 26;
    localparam int MS_PER_S        = 1000;
    localparam int SPEED_MAX       = 999;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_TICK,
        OP_RESTART,
        OP_PAUSE,
        OP_RUN
    } opcode_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        RS_INITIAL,
        RS_PAUSED,
        RS_RUNNING,
        RS_FINISHED
    } run_state_t;

    typedef enum logic [PHASE_WIDTH-1:0] {
        PH_WARMUP,
        PH_LOW,
        PH_HIGH,
        PH_WARMDOWN
    } phase_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_WARMUP,
        CFG_LOW,
        CFG_HIGH,
        CFG_WARMDOWN,
        CFG_REPEATS
    } cfg_index_t;

    // Per-phase speed (already clamped) and duration in milliseconds.
    typedef struct packed {
        logic [NUM_PHASES-1:0][SPEED_WIDTH-1:0] speed;
        logic [NUM_PHASES-1:0][DUR_WIDTH-1:0]   dur_ms;
        logic [COUNT_WIDTH-1:0]                 repeats;
    } profile_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic [ELAPSED_WIDTH-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] speed;
        run_state_t             run_state;
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] intervals;
        logic [TIMER_WIDTH-1:0] timer_ms;
    } status_t;

endpackage

/* src/interval_workout_sequencer.sv */
// Top level of the interval workout sequencer: input stage, engine and result register.
//
// Usage: program the four phase registers (speed in bits 25:16, seconds in
// bits 15:0) and the repeat count through the write port while no item is in
// flight. Items then enter on the s_ channel: tick, restart, pause or run.
// Every item yields exactly one result on the m_ channel, showing the demand
// speed, run status, phase, completed intervals and accumulated time after it.
//
// An accepted item waits in an input register, the engine computes the new
// state from it in a single pass, and the result register is loaded as the
// item leaves. The block sustains one item per clock cycle unless the receiver
// stalls; the input register empties whenever the result register is free or
// being read in the same cycle.
// When the receiver stalls, the result is held and one more item waits in
// the input register before s_ready drops.
//
// A synchronous low aresetn clears the configuration, the workout state
// (initial, warmup, zero counts and times) and both valid flags.
module interval_workout_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [iws_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [iws_pkg::OPCODE_WIDTH-1:0]    s_opcode,
    input  logic [iws_pkg::ELAPSED_WIDTH-1:0]   s_elapsed_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [iws_pkg::SPEED_WIDTH-1:0]     m_demand_speed,
    output logic [iws_pkg::STATUS_WIDTH-1:0]    m_run_status,
    output logic [iws_pkg::PHASE_WIDTH-1:0]     m_phase_now,
    output logic [iws_pkg::COUNT_WIDTH-1:0]     m_intervals_done,
    output logic [iws_pkg::OUT_TIME_WIDTH-1:0]  m_workout_time_ms
);
    import iws_pkg::*;

    logic     in_valid_reg, in_valid_next;
    item_t    item_reg;
    logic     out_valid_reg, out_valid_next;
    status_t  out_reg;
    status_t  result;
    profile_t profile;
    logic     advance;
    logic     in_xfer;

    iws_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .profile     (profile)
    );

    iws_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .profile (profile),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg.opcode     <= opcode_t'(s_opcode);
            item_reg.elapsed_ms <= s_elapsed_ms;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_demand_speed    = out_reg.speed;
    assign m_run_status      = out_reg.run_state;
    assign m_phase_now       = out_reg.phase;
    assign m_intervals_done  = out_reg.intervals;
    assign m_workout_time_ms = OUT_TIME_WIDTH'(out_reg.timer_ms);

endmodule

/* src/iws_cfg.sv */
// Configuration registers and the derived per-phase speed and duration table.
module iws_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [iws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [iws_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
    output iws_pkg::profile_t                   profile
);
    import iws_pkg::*;

    logic [CFG_WIDTH-1:0]   phase_cfg_reg [NUM_PHASES];
    logic [COUNT_WIDTH-1:0] repeats_reg;
    profile_t               profile_reg;
    profile_t               profile_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
                phase_cfg_reg[p] <= '0;
            end
            repeats_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_WARMUP, CFG_LOW, CFG_HIGH, CFG_WARMDOWN: begin
                    phase_cfg_reg[cfg_index[PHASE_IDX_WIDTH-1:0]] <= cfg_wr_data;
                end
                CFG_REPEATS: begin
                    repeats_reg <= cfg_wr_data[COUNT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamping and the seconds-to-milliseconds product are registered here so
    // the per-item path only has to select from the table.
    always_comb begin
        logic [SPEED_WIDTH-1:0] spd;
        logic [SECS_WIDTH-1:0]  secs;
        profile_next = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            spd  = phase_cfg_reg[p][CFG_WIDTH-1:SECS_WIDTH];
            secs = phase_cfg_reg[p][SECS_WIDTH-1:0];
            profile_next.speed[p]  = (spd > SPEED_WIDTH'(SPEED_MAX)) ?
                                     SPEED_WIDTH'(SPEED_MAX) : spd;
            profile_next.dur_ms[p] = DUR_WIDTH'(secs) * DUR_WIDTH'(MS_PER_S);
        end
        profile_next.repeats = repeats_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_reg <= '0;
        end else begin
            profile_reg <= profile_next;
        end
    end

    assign profile = profile_reg;

endmodule

/* src/iws_engine.sv */
// Workout state registers and the combinational next-state logic for one item.
module iws_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  iws_pkg::item_t    item,
    input  iws_pkg::profile_t profile,
    output iws_pkg::status_t  result
);
    import iws_pkg::*;

    localparam int SUM1_WIDTH = TIMER_WIDTH + 1;
    localparam int SUM3_WIDTH = TIMER_WIDTH + 2;

    run_state_t             run_state_reg, run_state_next;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] trans_reg, trans_next;
    logic [SPEED_WIDTH-1:0] speed_reg, speed_next;

    logic [SUM1_WIDTH-1:0]  sum_tick;
    logic [TIMER_WIDTH-1:0] timer_tick;
    logic                   reached;
    logic [COUNT_WIDTH-1:0] count_inc;
    phase_t                 phase_adv;
    logic [SUM3_WIDTH-1:0]  sum3;
    logic [TIMER_WIDTH-1:0] trans_tick;

    assign sum_tick   = {1'b0, timer_reg} + SUM1_WIDTH'(item.elapsed_ms);
    assign timer_tick = sum_tick[TIMER_WIDTH] ? TIMER_MAX : sum_tick[TIMER_WIDTH-1:0];
    assign reached    = (timer_tick >= trans_reg);
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb begin
        case (phase_reg)
            PH_WARMUP: begin
                phase_adv = (profile.repeats != '0) ? PH_LOW : PH_WARMDOWN;
            end
            PH_LOW: begin
                phase_adv = PH_HIGH;
            end
            PH_HIGH: begin
                phase_adv = (count_inc >= profile.repeats) ? PH_WARMDOWN : PH_LOW;
            end
            default: begin
                phase_adv = PH_WARMDOWN;
            end
        endcase
    end

    // The new deadline is the saturated timer plus the next phase's length.
    // Summing all three terms at once gives the same saturated value, since
    // an overflow of the timer alone already pushes the sum past the maximum.
    assign sum3 = SUM3_WIDTH'(timer_reg) + SUM3_WIDTH'(item.elapsed_ms)
                + SUM3_WIDTH'(profile.dur_ms[phase_adv]);
    assign trans_tick = (sum3 > SUM3_WIDTH'(TIMER_MAX)) ? TIMER_MAX
                                                         : sum3[TIMER_WIDTH-1:0];

    always_comb begin
        run_state_next = run_state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        timer_next     = timer_reg;
        trans_next     = trans_reg;
        speed_next     = speed_reg;
        if (step_en) begin
            case (item.opcode)
                OP_RESTART: begin
                    run_state_next = RS_INITIAL;
                    phase_next     = PH_WARMUP;
                    count_next     = '0;
                    timer_next     = '0;
                    trans_next     = TIMER_WIDTH'(profile.dur_ms[PH_WARMUP]);
                end
                OP_PAUSE: begin
                    run_state_next = RS_PAUSED;
                end
                OP_RUN: begin
                    run_state_next = RS_RUNNING;
                end
                default: begin
                    if (run_state_reg == RS_RUNNING) begin
                        speed_next = profile.speed[phase_reg];
                        timer_next = timer_tick;
                        if (reached) begin
                            if (phase_reg == PH_WARMDOWN) begin
                                run_state_next = RS_FINISHED;
                            end else begin
                                phase_next = phase_adv;
                                trans_next = trans_tick;
                                if (phase_reg == PH_WARMUP) begin
                                    count_next = '0;
                                end else if (phase_reg == PH_HIGH) begin
                                    count_next = count_inc;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg <= RS_INITIAL;
            phase_reg     <= PH_WARMUP;
            count_reg     <= '0;
            timer_reg     <= '0;
            trans_reg     <= '0;
            speed_reg     <= '0;
        end else begin
            run_state_reg <= run_state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            timer_reg     <= timer_next;
            trans_reg     <= trans_next;
            speed_reg     <= speed_next;
        end
    end

    // The result of an item is the state it leaves behind.
    always_comb begin
        result.speed     = speed_next;
        result.run_state = run_state_next;
        result.phase     = phase_next;
        result.intervals = count_next;
        result.timer_ms  = timer_next;
    end

endmodule

/* src/iws_checker.sv */
// Port-level checks of the interval workout sequencer and their binding.
module iws_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [iws_pkg::SPEED_WIDTH-1:0]     m_demand_speed,
    input logic [iws_pkg::STATUS_WIDTH-1:0]    m_run_status,
    input logic [iws_pkg::PHASE_WIDTH-1:0]     m_phase_now,
    input logic [iws_pkg::COUNT_WIDTH-1:0]     m_intervals_done,
    input logic [iws_pkg::OUT_TIME_WIDTH-1:0]  m_workout_time_ms
);
    import iws_pkg::*;

    logic                      have_last_reg;
    logic [OUT_TIME_WIDTH-1:0] last_time_reg;

    // Track the time shown by the previous result transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
            last_time_reg <= '0;
        end else if (m_valid && m_ready) begin
            have_last_reg <= 1'b1;
            last_time_reg <= m_workout_time_ms;
        end
    end

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_workout_time_ms)
                                   && $stable(m_run_status) && $stable(m_phase_now)))
        else $error("stalled result changed");

    a_speed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_demand_speed <= SPEED_WIDTH'(SPEED_MAX)))
        else $error("demand speed above limit");

    a_finished_in_warmdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_run_status == RS_FINISHED) |-> (m_phase_now == PH_WARMDOWN))
        else $error("finished outside warmdown");

    // Time only goes backward on a restart, which also clears phase and count.
    a_time_drop_is_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && have_last_reg && (m_workout_time_ms < last_time_reg))
        |-> (m_run_status == RS_INITIAL && m_phase_now == PH_WARMUP
             && m_intervals_done == '0))
        else $error("workout time decreased without a restart");

endmodule

bind interval_workout_sequencer iws_checker u_iws_checker (.*);

/* tb/sv/interval_workout_sequencer_tb.sv */
// Self-checking testbench for the interval workout sequencer: directed table, random workouts.
`timescale 1ns / 1ps

module interval_workout_sequencer_tb;
    import iws_pkg::*;

    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PLAN_ROWS    = 23;
    localparam int PROFILE_ROW  = 8;

    localparam logic [CFG_WIDTH-1:0] CFG_ALL_ONES = '1;

    typedef struct packed {
        opcode_t                  op;
        logic [ELAPSED_WIDTH-1:0] elapsed;
        logic                     typed;
        status_t                  want;
    } plan_row_t;

    // The first rows run on the reset profile, so their results can be written down directly.
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_TICK,    16'd0,     1'b1, '{10'd0, RS_INITIAL,  PH_WARMUP,   8'd0, 40'd0}},
        '{OP_TICK,    16'hFFFF,  1'b1, '{10'd0, RS_INITIAL,  PH_WARMUP,   8'd0, 40'd0}},
        '{OP_RUN,     16'd0,     1'b1, '{10'd0, RS_RUNNING,  PH_WARMUP,   8'd0, 40'd0}},
        '{OP_TICK,    16'd0,     1'b1, '{10'd0, RS_RUNNING,  PH_WARMDOWN, 8'd0, 40'd0}},
        '{OP_TICK,    16'hFFFF,  1'b1, '{10'd0, RS_FINISHED, PH_WARMDOWN, 8'd0, 40'd65535}},
        '{OP_TICK,    16'd1,     1'b1, '{10'd0, RS_FINISHED, PH_WARMDOWN, 8'd0, 40'd65535}},
        '{OP_PAUSE,   16'd0,     1'b1, '{10'd0, RS_PAUSED,   PH_WARMDOWN, 8'd0, 40'd65535}},
        '{OP_RESTART, 16'd0,     1'b1, '{10'd0, RS_INITIAL,  PH_WARMUP,   8'd0, 40'd0}},
        '{OP_RESTART, 16'hFFFF,  1'b0, '0},
        '{OP_RUN,     16'hAAAA,  1'b0, '0},
        '{OP_TICK,    16'd999,   1'b0, '0},
        '{OP_TICK,    16'd1,     1'b0, '0},
        '{OP_TICK,    16'hFFFF,  1'b0, '0},
        '{OP_TICK,    16'd0,     1'b0, '0},
        '{OP_PAUSE,   16'h5555,  1'b0, '0},
        '{OP_TICK,    16'hFFFF,  1'b0, '0},
        '{OP_RUN,     16'd0,     1'b0, '0},
        '{OP_TICK,    16'hFFFF,  1'b0, '0},
        '{OP_TICK,    16'hFFFF,  1'b0, '0},
        '{OP_TICK,    16'hFFFF,  1'b0, '0},
        '{OP_TICK,    16'd0,     1'b0, '0},
        '{OP_RUN,     16'd0,     1'b0, '0},
        '{OP_TICK,    16'd0,     1'b0, '0}
    };

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        cfg_wr_en    = 1'b0;
    cfg_index_t                  cfg_index    = CFG_WARMUP;
    logic [CFG_WIDTH-1:0]        cfg_wr_data  = '0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    opcode_t                     s_opcode     = OP_TICK;
    logic [ELAPSED_WIDTH-1:0]    s_elapsed_ms = '0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic [SPEED_WIDTH-1:0]      m_demand_speed;
    logic [STATUS_WIDTH-1:0]     m_run_status;
    logic [PHASE_WIDTH-1:0]      m_phase_now;
    logic [COUNT_WIDTH-1:0]      m_intervals_done;
    logic [OUT_TIME_WIDTH-1:0]   m_workout_time_ms;

    // Side information that travels with the item currently offered.
    logic    row_typed = 1'b0;
    status_t row_want  = '0;

    logic steady_run = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;

    status_t status_due [$];

    // Predictor copy of the profile and the workout state.
    logic [CFG_WIDTH-1:0]   phase_cfg [NUM_PHASES];
    logic [COUNT_WIDTH-1:0] wk_repeats    = '0;
    run_state_t             wk_state      = RS_INITIAL;
    phase_t                 wk_phase      = PH_WARMUP;
    logic [COUNT_WIDTH-1:0] wk_intervals  = '0;
    logic [TIMER_WIDTH-1:0] wk_timer      = '0;
    logic [TIMER_WIDTH-1:0] wk_transition = '0;
    logic [SPEED_WIDTH-1:0] wk_speed      = '0;

    initial begin
        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_cfg[p] = '0;
        end
    end

    interval_workout_sequencer i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_elapsed_ms      (s_elapsed_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_demand_speed    (m_demand_speed),
        .m_run_status      (m_run_status),
        .m_phase_now       (m_phase_now),
        .m_intervals_done  (m_intervals_done),
        .m_workout_time_ms (m_workout_time_ms)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [TIMER_WIDTH-1:0] timer_add_sat(logic [TIMER_WIDTH-1:0] a,
                                                             logic [TIMER_WIDTH-1:0] b);
        logic [TIMER_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIMER_WIDTH] ? TIMER_MAX : sum[TIMER_WIDTH-1:0];
    endfunction

    function automatic logic [TIMER_WIDTH-1:0] phase_duration_ms(phase_t p);
        return TIMER_WIDTH'(phase_cfg[p][SECS_WIDTH-1:0]) * TIMER_WIDTH'(MS_PER_S);
    endfunction

    function automatic logic [SPEED_WIDTH-1:0] phase_speed(phase_t p);
        logic [SPEED_WIDTH-1:0] raw;
        raw = phase_cfg[p][CFG_WIDTH-1:SECS_WIDTH];
        return (raw > SPEED_WIDTH'(SPEED_MAX)) ? SPEED_WIDTH'(SPEED_MAX) : raw;
    endfunction

    function automatic void enter_phase(phase_t p);
        wk_phase      = p;
        wk_transition = timer_add_sat(wk_timer, phase_duration_ms(p));
    endfunction

    // Advances the workout by one item and returns the status the block should report.
    function automatic status_t next_status(opcode_t op, logic [ELAPSED_WIDTH-1:0] elapsed);
        status_t st;
        case (op)
            OP_RESTART: begin
                wk_state      = RS_INITIAL;
                wk_timer      = '0;
                wk_phase      = PH_WARMUP;
                wk_transition = phase_duration_ms(PH_WARMUP);
                wk_intervals  = '0;
            end
            OP_PAUSE: wk_state = RS_PAUSED;
            OP_RUN:   wk_state = RS_RUNNING;
            default: begin
                if (wk_state == RS_RUNNING) begin
                    wk_speed = phase_speed(wk_phase);
                    wk_timer = timer_add_sat(wk_timer, TIMER_WIDTH'(elapsed));
                    if (wk_timer >= wk_transition) begin
                        case (wk_phase)
                            PH_WARMUP: begin
                                wk_intervals = '0;
                                enter_phase((wk_repeats != 0) ? PH_LOW : PH_WARMDOWN);
                            end
                            PH_LOW: enter_phase(PH_HIGH);
                            PH_HIGH: begin
                                if (wk_intervals != '1) begin
                                    wk_intervals = wk_intervals + 1'b1;
                                end
                                enter_phase((wk_intervals >= wk_repeats) ? PH_WARMDOWN : PH_LOW);
                            end
                            default: wk_state = RS_FINISHED;
                        endcase
                    end
                end
            end
        endcase
        st.speed     = wk_speed;
        st.run_state = wk_state;
        st.phase     = wk_phase;
        st.intervals = wk_intervals;
        st.timer_ms  = wk_timer;
        return st;
    endfunction

    function automatic logic [ELAPSED_WIDTH-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ELAPSED_WIDTH'($urandom_range(0, 65535));
            default: return ELAPSED_WIDTH'($urandom_range(0, 1500));
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] random_phase_cfg();
        logic [SECS_WIDTH-1:0] secs;
        secs = ($urandom_range(0, 9) == 0) ? SECS_WIDTH'($urandom_range(0, 65535))
                                           : SECS_WIDTH'($urandom_range(0, 3));
        return {SPEED_WIDTH'($urandom_range(0, 1023)), secs};
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] random_repeats();
        return ($urandom_range(0, 3) == 0) ? COUNT_WIDTH'($urandom_range(0, 255))
                                           : COUNT_WIDTH'($urandom_range(0, 4));
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        if (idx == CFG_REPEATS) begin
            wk_repeats = value[COUNT_WIDTH-1:0];
        end else begin
            phase_cfg[idx[PHASE_IDX_WIDTH-1:0]] = value;
        end
        @(posedge aclk);
    endtask

    task automatic program_profile(logic [CFG_WIDTH-1:0] warmup, logic [CFG_WIDTH-1:0] low,
                                   logic [CFG_WIDTH-1:0] high, logic [CFG_WIDTH-1:0] warmdown,
                                   logic [COUNT_WIDTH-1:0] repeats);
        write_reg(CFG_WARMUP, warmup);
        write_reg(CFG_LOW, low);
        write_reg(CFG_HIGH, high);
        write_reg(CFG_WARMDOWN, warmdown);
        write_reg(CFG_REPEATS, CFG_WIDTH'(repeats));
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(opcode_t op, logic [ELAPSED_WIDTH-1:0] elapsed,
                             logic typed, status_t want);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_elapsed_ms <= elapsed;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (results_seen < items_sent) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly restart, run and a burst of ticks; noise_pct of the items are
    // pauses, runs and restarts dropped in at random.
    task automatic run_workouts(int n_items, int noise_pct, bit resume, bit single);
        int sent;
        int burst;
        int r;
        sent = 0;
        while (sent < n_items) begin
            if (!(resume && sent == 0)) begin
                send_item(OP_RESTART, pick_elapsed(), 1'b0, '0);
                send_item(OP_RUN, pick_elapsed(), 1'b0, '0);
                sent += 2;
            end
            burst = single ? n_items : $urandom_range(4, 24);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                r = $urandom_range(0, 99);
                if (r < noise_pct / 3) begin
                    send_item(OP_PAUSE, pick_elapsed(), 1'b0, '0);
                end else if (r < (2 * noise_pct) / 3) begin
                    send_item(OP_RUN, pick_elapsed(), 1'b0, '0);
                end else if (r < noise_pct) begin
                    send_item(OP_RESTART, pick_elapsed(), 1'b0, '0);
                end else begin
                    send_item(OP_TICK, pick_elapsed(), 1'b0, '0);
                end
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (steady_run) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        status_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = next_status(s_opcode, s_elapsed_ms);
                if (row_typed) begin
                    want = row_want;
                end
                status_due.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    err_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("demand_speed", want.speed, m_demand_speed);
                    check_field("run_status", want.run_state, m_run_status);
                    check_field("phase_now", want.phase, m_phase_now);
                    check_field("intervals_done", want.intervals, m_intervals_done);
                    check_field("workout_time_ms", OUT_TIME_WIDTH'(want.timer_ms),
                                m_workout_time_ms);
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("interval_workout_sequencer_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (i == PROFILE_ROW) begin
                wait_results();
                // Speeds above the limit in warmup and low, zero-length warmdown.
                program_profile({10'd1023, 16'd1}, {10'd1000, 16'd1}, {10'd0, 16'd2},
                                {10'd999, 16'd0}, 8'd2);
            end
            send_item(plan[i].op, plan[i].elapsed, plan[i].typed, plan[i].want);
        end
        wait_results();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_profile(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, '1);
                // Zero-length phases: every tick moves on, so the interval count climbs.
                1: program_profile({10'd300, 16'd0}, {10'd200, 16'd0}, {10'd800, 16'd0},
                                   {10'd100, 16'd0}, '1);
                // Repeat count drops below the count reached by the workout still in progress.
                2: program_profile(random_phase_cfg(), random_phase_cfg(), random_phase_cfg(),
                                   random_phase_cfg(), COUNT_WIDTH'($urandom_range(0, 5)));
                default: program_profile(random_phase_cfg(), random_phase_cfg(),
                                         random_phase_cfg(), random_phase_cfg(),
                                         random_repeats());
            endcase
            steady_run <= (ph == 3);
            if (ph == 2) begin
                hold_req <= 1'b1;
            end
            case (ph)
                0:       run_workouts(50, 15, 1'b0, 1'b0);
                1:       run_workouts(320, 1, 1'b0, 1'b1);
                2:       run_workouts(60, 10, 1'b1, 1'b0);
                default: run_workouts(60, 15, 1'b0, 1'b0);
            endcase
            wait_results();
        end

        if (status_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, status_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("interval_workout_sequencer_tb: clean");
        end else begin
            $display("interval_workout_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
